>>> rtl/ppba_pkg.sv
// Shared types, codes and helpers for the physical page bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package ppba_pkg;

    localparam int PAGE_SHIFT = 12;
    localparam int WORD_BITS  = 32;
    localparam int LIMIT_W    = 15;

    localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET = 15'd16384;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] STAT_ALLOCATED    = 3'd0;
    localparam logic [2:0] STAT_OUT_OF_PAGES = 3'd1;
    localparam logic [2:0] STAT_RELEASED     = 3'd3;
    localparam logic [2:0] STAT_IGNORED      = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [31:0] page_address;
    } req_t;

    typedef struct packed {
        logic [31:0] alloc_address;
        logic [2:0]  status;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE
    } state_t;

    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } zero_hit_t;

    // Lowest clear bit of a map word.
    function automatic zero_hit_t first_zero(input logic [WORD_BITS-1:0] w);
        zero_hit_t r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r.found = 1'b1;
                r.idx   = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ppba_map.sv
// Used-page bitmap store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ppba_map #(
    parameter int WORDS = 512
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(WORDS)-1:0]   wr_addr,
    input  wire logic [31:0]                wr_data,
    input  wire logic [$clog2(WORDS)-1:0]   rd_addr,
    output logic      [31:0]                rd_data
);

    logic [31:0] mem [WORDS];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/phys_page_bitmap_allocator.sv
// Top level of the physical page allocator: sequencer, config register and result register.
`timescale 1ns / 1ps
`default_nettype none

// Allocate: the scan reads the bitmap one word a cycle through the single read port, from
//   the word holding the first page above the low region, until a free page below the
//   search end turns up or the search end is reached.
// Free: read, then clear the bit; a free outside the managed range is answered from idle.
// Reset: a clearing pass writes every map word with busy high; config writes are taken
//   during it. Results cannot be stalled.
module phys_page_bitmap_allocator #(
    parameter int MAX_PAGES      = 16384,
    parameter int RESERVED_PAGES = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire ppba_pkg::req_t                  req,
    output logic                                 done,
    output ppba_pkg::rsp_t                       rsp,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ppba_pkg::LIMIT_W-1:0]    cfg_data
);

    import ppba_pkg::*;

    localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WW        = $clog2(MAP_WORDS);
    localparam int PW        = WW + 5;            // page index width
    localparam int EW        = PW + 1;            // search end, may equal MAX_PAGES
    localparam int CW        = (EW > LIMIT_W) ? EW : LIMIT_W;
    localparam int RES_WORD  = RESERVED_PAGES / WORD_BITS;

    localparam logic [WW-1:0] LAST_WORD  = WW'(MAP_WORDS - 1);
    localparam logic [WW-1:0] START_WORD = WW'(RES_WORD);
    localparam logic [31:0]   PART_MASK  =
        32'((64'd1 << (RESERVED_PAGES % WORD_BITS)) - 64'd1);
    localparam logic [31:0]   LOW_LIMIT  = 32'(RESERVED_PAGES) << PAGE_SHIFT;
    localparam logic [CW-1:0] MAXP_C     = CW'(MAX_PAGES);
    localparam logic [CW-1:0] RES_C      = CW'(RESERVED_PAGES);
    localparam logic [20:0]   MAXP_F     = 21'(MAX_PAGES);

    // Control state
    state_t                 state_reg, state_next;
    logic [WW-1:0]          word_reg, word_next;
    logic                   done_reg, done_next;
    logic [LIMIT_W-1:0]     page_limit_reg;

    // Item payload
    logic [4:0]             bit_reg, bit_next;
    logic [EW-1:0]          end_reg, end_next;
    rsp_t                   rsp_reg, rsp_next;

    // Map port
    logic                   wr_en;
    logic [31:0]            wr_data;
    logic [31:0]            rd_data;

    zero_hit_t              hit;
    logic [CW-1:0]          lim_c;
    logic [CW-1:0]          end_c;
    logic [PW-1:0]          hit_page;
    logic [EW-1:0]          next_base;
    logic [19:0]            free_pg;
    logic                   free_ok;

    ppba_map #(
        .WORDS (MAP_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (word_reg),
        .wr_data (wr_data),
        .rd_addr (word_next),
        .rd_data (rd_data)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // Clamp the configured limit to the store.
    assign lim_c = CW'(page_limit_reg);
    assign end_c = (lim_c < MAXP_C) ? lim_c : MAXP_C;

    assign hit       = first_zero(rd_data);
    assign hit_page  = {word_reg, hit.idx};
    // First page of the word after the current one.
    assign next_base = {(WW + 1)'({1'b0, word_reg}) + (WW + 1)'(1), 5'd0};

    // A reference count only ever holds 0 or 1 above the low region, so the used
    // bit stands in for it: a set bit means count 1.
    assign free_pg = req.page_address[31:PAGE_SHIFT];
    assign free_ok = (req.page_address >= LOW_LIMIT) && ({1'b0, free_pg} < MAXP_F);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            word_reg       <= '0;
            done_reg       <= 1'b0;
            page_limit_reg <= PAGE_LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                page_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
        end_reg <= end_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        bit_next   = bit_reg;
        end_next   = end_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        wr_en      = 1'b0;
        wr_data    = rd_data;

        case (state_reg)
            ST_CLEAR:
            begin
                // Walk the map once: low region set, everything else clear.
                wr_en = 1'b1;
                if (32'(word_reg) < 32'(RES_WORD))
                begin
                    wr_data = '1;
                end
                else if (32'(word_reg) == 32'(RES_WORD))
                begin
                    wr_data = PART_MASK;
                end
                else
                begin
                    wr_data = '0;
                end
                if (word_reg == LAST_WORD)
                begin
                    word_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    word_next = word_reg + WW'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.operation == OP_ALLOC)
                    begin
                        if (end_c <= RES_C)
                        begin
                            // Nothing above the low region to search.
                            done_next = 1'b1;
                            rsp_next  = '{alloc_address: 32'd0, status: STAT_OUT_OF_PAGES};
                        end
                        else
                        begin
                            end_next   = EW'(end_c);
                            word_next  = START_WORD;
                            state_next = ST_SCAN;
                        end
                    end
                    else if (free_ok)
                    begin
                        word_next  = free_pg[5 +: WW];
                        bit_next   = free_pg[4:0];
                        state_next = ST_FREE;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{alloc_address: 32'd0, status: STAT_IGNORED};
                    end
                end
            end

            ST_SCAN:
            begin
                if (hit.found && (EW'(hit_page) < end_reg))
                begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data | (32'd1 << hit.idx);
                    done_next  = 1'b1;
                    rsp_next   = '{alloc_address: 32'(hit_page) << PAGE_SHIFT,
                                   status: STAT_ALLOCATED};
                    state_next = ST_IDLE;
                end
                else if (next_base >= end_reg)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{alloc_address: 32'd0, status: STAT_OUT_OF_PAGES};
                    state_next = ST_IDLE;
                end
                else
                begin
                    // Advance to the next word; its read is already issued.
                    word_next = word_reg + WW'(1);
                end
            end

            ST_FREE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (rd_data[bit_reg])
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data & ~(32'd1 << bit_reg);
                    rsp_next = '{alloc_address: 32'd0, status: STAT_RELEASED};
                end
                else
                begin
                    rsp_next = '{alloc_address: 32'd0, status: STAT_IGNORED};
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A granted page lies at or above the low region and below the search end.
    a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STAT_ALLOCATED) |->
            (rsp.alloc_address >= LOW_LIMIT) &&
            (EW'(rsp.alloc_address[31:PAGE_SHIFT]) < end_reg))
        else $error("allocated page outside search window");

    // Every result other than a grant carries address zero.
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != STAT_ALLOCATED) |-> (rsp.alloc_address == 32'd0))
        else $error("non-grant result with nonzero address");

    // A result follows an accepted request or work in flight.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) || $past(busy)))
        else $error("result without a request");

    // The map is written only while the sequencer is at work.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> busy)
        else $error("map write while idle");

    // No result comes out of the clearing pass.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !done)
        else $error("result during clearing pass");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the physical page bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import ppba_pkg::*;

    localparam int MAX_PAGES      = 16384;
    localparam int RESERVED_PAGES = 1024;

    // The package names no code for a count that drops without reaching zero.
    localparam logic [2:0]         STAT_DROPPED = 3'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX    = '1;

    // Page frame ledger: mirrors the used map and reference counts, predicts the
    // result of every accepted request and checks the results in order.
    class frame_ledger;
        logic [LIMIT_W-1:0] limit;
        bit                 used_pg[MAX_PAGES];
        logic [15:0]        ref_cnt[MAX_PAGES];
        int unsigned        live[$];
        rsp_t               expected_q[$];
        int                 errors;
        int                 accepted;
        int                 seen[8];

        function new();
            for (int pg = 0; pg < MAX_PAGES; pg++)
            begin
                used_pg[pg] = (pg < RESERVED_PAGES);
                ref_cnt[pg] = (pg < RESERVED_PAGES) ? 16'd1 : 16'd0;
            end
            limit    = PAGE_LIMIT_RESET;
            errors   = 0;
            accepted = 0;
            foreach (seen[i])
                seen[i] = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] v);
            limit = v;
        endfunction

        // Work out the result of one accepted request and queue it.
        function void note_request(req_t r);
            rsp_t        want;
            int unsigned stop;
            int unsigned pg;
            want = '0;
            accepted++;
            if (r.operation == OP_ALLOC)
            begin
                // first fit from the top of the reserved region, below the limit
                stop = (limit > MAX_PAGES) ? MAX_PAGES : int'(limit);
                want.status = STAT_OUT_OF_PAGES;
                for (pg = RESERVED_PAGES; pg < stop; pg++)
                begin
                    if (!used_pg[pg])
                    begin
                        used_pg[pg]        = 1'b1;
                        ref_cnt[pg]        = 16'd1;
                        want.alloc_address = 32'(pg) << PAGE_SHIFT;
                        want.status        = STAT_ALLOCATED;
                        live.push_back(pg);
                        break;
                    end
                end
            end
            else
            begin
                pg = r.page_address >> PAGE_SHIFT;
                want.status = STAT_IGNORED;
                if ((r.page_address >= (32'(RESERVED_PAGES) << PAGE_SHIFT)) &&
                    (pg < MAX_PAGES) && (ref_cnt[pg] != 16'd0))
                begin
                    ref_cnt[pg] = ref_cnt[pg] - 16'd1;
                    if (ref_cnt[pg] == 16'd0)
                    begin
                        used_pg[pg] = 1'b0;
                        want.status = STAT_RELEASED;
                        foreach (live[i])
                        begin
                            if (live[i] == pg)
                            begin
                                live.delete(i);
                                break;
                            end
                        end
                    end
                    else
                        want.status = STAT_DROPPED;
                end
            end
            expected_q.push_back(want);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with none pending: alloc_address %h status %0d",
                       got.alloc_address, got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            seen[got.status]++;
            if (got.alloc_address !== want.alloc_address)
            begin
                $error("alloc_address: expected %h, actual %h",
                       want.alloc_address, got.alloc_address);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    req_t               req       = '0;
    logic               done;
    rsp_t               rsp;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data  = PAGE_LIMIT_RESET;

    frame_ledger ledger;
    bit          steady       = 1'b0;
    int          limit_writes = 0;

    phys_page_bitmap_allocator #(
        .MAX_PAGES      (MAX_PAGES),
        .RESERVED_PAGES (RESERVED_PAGES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Results cannot be held off: check every strobe at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.check_response(rsp);
    end

    function automatic logic [31:0] page_addr(int unsigned pg);
        return 32'(pg) << PAGE_SHIFT;
    endfunction

    // Issue one request; now and then idle with start low first. Keep start
    // high after acceptance so back-to-back requests need no second write.
    task automatic request(logic op, logic [31:0] addr);
        req_t        r;
        int unsigned gap;
        r.operation    = op;
        r.page_address = addr;
        if (!steady && $urandom_range(0, 99) < 13)
        begin
            // mostly short gaps, sometimes long enough to land inside a scan
            gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        ledger.note_request(r);
    endtask

    // Drop start and hold until every pending result has come back.
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (ledger.expected_q.size() != 0);
    endtask

    // Write page_limit; only called while no request is in flight.
    task automatic write_limit(logic [LIMIT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        ledger.set_limit(v);
        limit_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] lim;
        logic [31:0]        addr;
        logic               op;
        int unsigned        sel;
        int unsigned        pg;
        int                 n;

        ledger = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // The write is taken during the clearing pass after reset.
        write_limit(LIMIT_W'(RESERVED_PAGES + 16));

        // Frees that must be ignored: low memory, beyond the store, unused page.
        request(OP_FREE, 32'h0000_0000);
        request(OP_FREE, page_addr(RESERVED_PAGES) - 32'd1);
        request(OP_FREE, 32'hFFFF_FFFF);
        request(OP_FREE, page_addr(MAX_PAGES));
        request(OP_FREE, page_addr(RESERVED_PAGES));
        // First fit, unaligned free, refill of a hole, double free.
        request(OP_ALLOC, $urandom);
        request(OP_FREE, page_addr(RESERVED_PAGES) | 32'hFFF);
        request(OP_ALLOC, 32'hFFFF_FFFF);
        request(OP_ALLOC, 32'h0000_0000);
        request(OP_ALLOC, $urandom);
        request(OP_FREE, page_addr(RESERVED_PAGES + 1) | 32'h800);
        request(OP_ALLOC, $urandom);
        request(OP_FREE, page_addr(RESERVED_PAGES + 1));
        request(OP_FREE, page_addr(RESERVED_PAGES + 1));

        // Limit at a live page: fill the window below it, then free the live page at the limit.
        settle();
        write_limit(LIMIT_W'(RESERVED_PAGES + 2));
        request(OP_ALLOC, $urandom);
        request(OP_ALLOC, $urandom);
        request(OP_FREE, page_addr(RESERVED_PAGES + 2));
        request(OP_ALLOC, $urandom);

        // Limit at the reserved boundary, then a limit of one page.
        settle();
        write_limit(LIMIT_W'(RESERVED_PAGES));
        request(OP_ALLOC, $urandom);
        settle();
        write_limit(LIMIT_W'(1));
        request(OP_ALLOC, $urandom);

        // Limit above the store, then back to the reset value.
        settle();
        write_limit(LIMIT_MAX);
        request(OP_ALLOC, $urandom);
        settle();
        write_limit(PAGE_LIMIT_RESET);
        request(OP_ALLOC, $urandom);

        // Random part: six phases with different limits. Most frees hit live
        // pages so the map keeps turning over; the rest are noise.
        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            case (ph)
                0:       lim = PAGE_LIMIT_RESET;
                1:       lim = LIMIT_W'(RESERVED_PAGES + $urandom_range(1, 48));
                2:       lim = LIMIT_MAX;
                3:       lim = LIMIT_W'($urandom_range(RESERVED_PAGES + 1, MAX_PAGES - 1));
                4:       lim = LIMIT_W'($urandom_range(1, RESERVED_PAGES));
                default: lim = LIMIT_W'(RESERVED_PAGES + $urandom_range(49, 400));
            endcase
            write_limit(lim);
            for (int k = 0; k < 75; k++)
            begin
                n      = ph * 75 + k;
                steady = (n >= 150 && n < 250);
                // now and then hold the sender until the block has drained
                if ($urandom_range(0, 99) == 0)
                    settle();
                op = (ledger.live.size() == 0 || $urandom_range(0, 99) < 55) ?
                     OP_ALLOC : OP_FREE;
                addr = $urandom;
                if (op == OP_FREE)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 70 && ledger.live.size() != 0)
                    begin
                        pg   = ledger.live[$urandom_range(0, ledger.live.size() - 1)];
                        addr = page_addr(pg) | 32'($urandom_range(0, 4095));
                    end
                    else if (sel < 80)
                        addr = page_addr($urandom_range(RESERVED_PAGES, MAX_PAGES - 1)) |
                               32'($urandom_range(0, 4095));
                    else if (sel < 90)
                        addr = $urandom;
                    else if (sel < 95)
                        addr = $urandom_range(0, page_addr(RESERVED_PAGES) - 1);
                    else
                        addr = $urandom_range(page_addr(MAX_PAGES), 32'hFFFF_FFFF);
                end
                request(op, addr);
            end
        end
        steady = 1'b0;

        // Drain, then watch for stray strobes for longer than the slowest scan.
        settle();
        repeat (600) @(posedge clk);

        $display("Covered %0d requests under %0d page limit writes, from 1 up to %0d.",
                 ledger.accepted, limit_writes, LIMIT_MAX);
        $display("Results: %0d allocated, %0d out of pages, %0d released, %0d ignored.",
                 ledger.seen[STAT_ALLOCATED], ledger.seen[STAT_OUT_OF_PAGES],
                 ledger.seen[STAT_RELEASED], ledger.seen[STAT_IGNORED]);
        if (ledger.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/ppba_pkg.sv
rtl/ppba_map.sv
rtl/phys_page_bitmap_allocator.sv
sim/tb_top.sv
